// File: hdl/sart_pkg.sv
// Shared constants, status codes and control structs of the selective-ack receive tracker.
package sart_pkg;

    localparam int HELD_DEPTH   = 32;
    localparam int REORDER_SPAN = 4096;
    localparam int SACK_BITS    = 128;

    localparam int SEQ_W      = 16;
    localparam int SACK_W     = 128;
    localparam int SACK_IDX_W = 7;
    localparam int IDX_W      = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
    localparam int COUNT_W    = $clog2(HELD_DEPTH + 1);
    localparam int STATUS_W   = 3;

    localparam logic [SEQ_W-1:0] SEQ_RESET = 16'hfff0;

    typedef enum logic [STATUS_W-1:0] {
        ST_IN_ORDER  = 3'd0,
        ST_STORED    = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_STALE     = 3'd3,
        ST_FULL      = 3'd4
    } arrival_status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic classify;
        logic advance;
        logic scan;
        logic publish;
    } sart_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_order;
        logic adv_hit;
        logic scan_last;
    } sart_sts_t;

endpackage

// File: hdl/sart_datapath.sv
// Datapath: expected number, held store with match logic, bitmap scan and result registers.
module sart_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sart_pkg::sart_cmd_t    cmd,
    output sart_pkg::sart_sts_t    sts,
    input  logic [15:0]            arrived_seq,
    input  logic [15:0]            peer_window_base,
    output logic [15:0]            expected_next,
    output logic [63:0]            sack_low,
    output logic [63:0]            sack_high,
    output logic                   has_gap,
    output logic [5:0]             held_count,
    output logic [2:0]             arrival_status
);
    import sart_pkg::*;

    localparam logic [SEQ_W-1:0] SPAN_LIMIT = SEQ_W'(REORDER_SPAN);
    localparam logic [SEQ_W-1:0] SACK_LIMIT = SEQ_W'(SACK_BITS);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(HELD_DEPTH - 1);

    // Control state
    logic [SEQ_W-1:0]      next_expected_reg, next_expected_next;
    logic                  started_reg, started_next;
    logic [HELD_DEPTH-1:0] held_valid_reg, held_valid_next;
    logic [IDX_W-1:0]      scan_idx_reg, scan_idx_next;

    // Working and payload registers
    logic [SEQ_W-1:0]      held_seq_mem [HELD_DEPTH];
    logic [SEQ_W-1:0]      seq_reg, seq_next;
    arrival_status_t       status_reg, status_next;
    logic [SACK_W-1:0]     sack_reg, sack_next;
    logic [COUNT_W-1:0]    count_reg, count_next;

    logic [SEQ_W-1:0]      out_expected_reg;
    logic [SACK_W-1:0]     out_sack_reg;
    logic                  out_gap_reg;
    logic [5:0]            out_count_reg;
    logic [STATUS_W-1:0]   out_status_reg;

    // Match and slot selection
    logic [SEQ_W-1:0]      key;
    logic [HELD_DEPTH-1:0] key_match;
    logic                  any_match;
    logic [IDX_W-1:0]      match_idx;
    logic                  any_free;
    logic [IDX_W-1:0]      free_idx;
    logic                  store_en;
    logic [SEQ_W-1:0]      seq_dist;
    logic                  in_order;
    logic                  in_span;
    logic [SEQ_W-1:0]      scan_entry;
    logic [SEQ_W-1:0]      scan_bit;

    // Compare every held entry against the key; pick lowest match and lowest free slot
    always_comb
    begin
        key       = cmd.advance ? next_expected_reg : seq_reg;
        match_idx = '0;
        free_idx  = '0;
        for (int i = HELD_DEPTH - 1; i >= 0; i--)
        begin
            key_match[i] = held_valid_reg[i] && (held_seq_mem[i] == key);
            if (key_match[i])
            begin
                match_idx = IDX_W'(i);
            end
            if (!held_valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
        any_match = |key_match;
        any_free  = ~&held_valid_reg;
    end

    // Classify the arrival by serial distance
    assign seq_dist = seq_reg - next_expected_reg;
    assign in_order = (seq_dist == '0);
    assign in_span  = !in_order && (seq_dist < SPAN_LIMIT);

    // Read one held entry per scan step
    assign scan_entry = held_seq_mem[scan_idx_reg];
    assign scan_bit   = scan_entry - next_expected_reg - SEQ_W'(1);

    // Next-state logic for all commands
    always_comb
    begin
        next_expected_next = next_expected_reg;
        started_next       = started_reg;
        held_valid_next    = held_valid_reg;
        scan_idx_next      = scan_idx_reg;
        seq_next           = seq_reg;
        status_next        = status_reg;
        sack_next          = sack_reg;
        count_next         = count_reg;
        store_en           = 1'b0;

        if (cmd.load)
        begin
            seq_next      = arrived_seq;
            scan_idx_next = '0;
            sack_next     = '0;
            count_next    = '0;
            if (!started_reg)
            begin
                next_expected_next = peer_window_base;
                started_next       = 1'b1;
            end
        end

        if (cmd.classify)
        begin
            if (in_order)
            begin
                status_next        = ST_IN_ORDER;
                next_expected_next = next_expected_reg + SEQ_W'(1);
            end
            else if (in_span)
            begin
                if (any_match)
                begin
                    status_next = ST_DUPLICATE;
                end
                else if (any_free)
                begin
                    status_next               = ST_STORED;
                    held_valid_next[free_idx] = 1'b1;
                    store_en                  = 1'b1;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            else
            begin
                status_next = ST_STALE;
            end
        end

        // Take the held entry equal to the expected number and step past it
        if (cmd.advance && any_match)
        begin
            held_valid_next[match_idx] = 1'b0;
            next_expected_next         = next_expected_reg + SEQ_W'(1);
        end

        // Count one entry and set its bitmap position
        if (cmd.scan)
        begin
            scan_idx_next = scan_idx_reg + IDX_W'(1);
            if (held_valid_reg[scan_idx_reg])
            begin
                count_next = count_reg + COUNT_W'(1);
                if (scan_bit < SACK_LIMIT)
                begin
                    sack_next[scan_bit[SACK_IDX_W-1:0]] = 1'b1;
                end
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_expected_reg <= SEQ_RESET;
            started_reg       <= 1'b0;
            held_valid_reg    <= '0;
            scan_idx_reg      <= '0;
        end
        else
        begin
            next_expected_reg <= next_expected_next;
            started_reg       <= started_next;
            held_valid_reg    <= held_valid_next;
            scan_idx_reg      <= scan_idx_next;
        end
    end

    // Hold working payload and write the held store
    always_ff @(posedge clk)
    begin
        seq_reg    <= seq_next;
        status_reg <= status_next;
        sack_reg   <= sack_next;
        count_reg  <= count_next;
        if (store_en)
        begin
            held_seq_mem[free_idx] <= seq_reg;
        end
    end

    // Load the result registers
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_expected_reg <= next_expected_reg;
            out_sack_reg     <= sack_reg;
            out_gap_reg      <= (count_reg != '0);
            out_count_reg    <= 6'(count_reg);
            out_status_reg   <= status_reg;
        end
    end

    assign expected_next  = out_expected_reg;
    assign sack_low       = out_sack_reg[63:0];
    assign sack_high      = out_sack_reg[127:64];
    assign has_gap        = out_gap_reg;
    assign held_count     = out_count_reg;
    assign arrival_status = out_status_reg;

    assign sts.in_order  = in_order;
    assign sts.adv_hit   = any_match;
    assign sts.scan_last = (scan_idx_reg == LAST_IDX);

    // Held numbers are unique, so at most one entry matches any key
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(key_match))
        else $error("more than one held entry matches the key");

    // A stored arrival fills exactly one more slot
    assert property (@(posedge clk) disable iff (!rst_n)
        store_en |=> $countones(held_valid_reg) == $countones($past(held_valid_reg)) + 1)
        else $error("store did not fill exactly one slot");

    // A catch-up step removes one entry and moves the expected number by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.advance && any_match) |=>
            (next_expected_reg == $past(next_expected_reg) + SEQ_W'(1)) &&
            ($countones(held_valid_reg) + 1 == $countones($past(held_valid_reg))))
        else $error("catch-up step did not take exactly one entry");

endmodule

// File: hdl/sart_ctrl.sv
// Controller: sequences classify, catch-up advance, bitmap scan and result publish.
module sart_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    output sart_pkg::sart_cmd_t cmd,
    input  sart_pkg::sart_sts_t sts
);
    import sart_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_ADVANCE,
        S_SCAN,
        S_PUBLISH
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    // Select the next state
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CLASSIFY;
                end
            end
            S_CLASSIFY:
            begin
                state_next = sts.in_order ? S_ADVANCE : S_SCAN;
            end
            S_ADVANCE:
            begin
                if (!sts.adv_hit)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = S_PUBLISH;
                end
            end
            S_PUBLISH:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Decode commands from the state
    assign cmd.load     = (state_reg == S_IDLE) && start;
    assign cmd.classify = (state_reg == S_CLASSIFY);
    assign cmd.advance  = (state_reg == S_ADVANCE);
    assign cmd.scan     = (state_reg == S_SCAN);
    assign cmd.publish  = (state_reg == S_PUBLISH);

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    // An accepted transfer always starts with classification
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_CLASSIFY))
        else $error("accepted transfer did not enter classify");

    // The strobe follows the publish cycle and nothing else
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_PUBLISH))
        else $error("result strobe without publish");

    // The scan ends on its last entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && sts.scan_last) |=> (state_reg == S_PUBLISH))
        else $error("scan did not end at the last entry");

endmodule

// File: hdl/selective_ack_receive_tracker.sv
// Top level of the selective-ack receive tracker: controller plus datapath.
//
// Usage: present arrived_seq and peer_window_base with start high; the
// transfer is taken at a rising edge where start is high and busy is low.
// peer_window_base matters only for the first transfer after reset, which
// adopts it as the expected number.
// Each transfer yields one result: expected_next, sack_low, sack_high,
// has_gap, held_count and arrival_status, valid for the single cycle in
// which done is high. The receiver cannot stall; the result ports hold their
// value until the next result, but only the done cycle counts.
// Sequence: a classify step; then, for an in-order arrival, catch-up steps
// that take the held numbers now in order, one match at a time over the
// held store; then a scan over all HELD_DEPTH slots building the bitmap one
// held entry at a time; then a publish step. The next transfer can be taken
// in the done cycle.
// Reset: expected number 0xfff0, not started, held store empty, busy low.
module selective_ack_receive_tracker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] arrived_seq,
    input  logic [15:0] peer_window_base,
    output logic        done,
    output logic [15:0] expected_next,
    output logic [63:0] sack_low,
    output logic [63:0] sack_high,
    output logic        has_gap,
    output logic [5:0]  held_count,
    output logic [2:0]  arrival_status
);
    import sart_pkg::*;

    sart_cmd_t cmd;
    sart_sts_t sts;

    // Sequence each transfer
    sart_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    // Track sequence state and build results
    sart_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .arrived_seq      (arrived_seq),
        .peer_window_base (peer_window_base),
        .expected_next    (expected_next),
        .sack_low         (sack_low),
        .sack_high        (sack_high),
        .has_gap          (has_gap),
        .held_count       (held_count),
        .arrival_status   (arrival_status)
    );

endmodule

// File: bench/sart_scoreboard_pkg.sv
// Scoreboard class with its own receive-window predictor for the selective-ack tracker bench.
package sart_scoreboard_pkg;

    import sart_pkg::*;

    // One predicted or observed result of the tracker
    typedef struct {
        logic [15:0]     expected_next;
        logic [127:0]    sack;
        logic            has_gap;
        logic [5:0]      held_count;
        arrival_status_t status;
    } ack_report_t;

    class receive_window_scoreboard;

        logic [15:0]    next_seq;
        bit             started;
        logic [15:0]    held_seq [HELD_DEPTH];
        bit             held_valid [HELD_DEPTH];
        ack_report_t    pending_reports [$];
        int unsigned    faults;
        int unsigned    reports_checked;
        int unsigned    status_hits [5];
        int unsigned    deepest_store;
        int unsigned    longest_catch_up;

        function new();
            next_seq = SEQ_RESET;
            started = 1'b0;
            faults = 0;
            reports_checked = 0;
            deepest_store = 0;
            longest_catch_up = 0;
            foreach (held_valid[i])
            begin
                held_valid[i] = 1'b0;
                held_seq[i] = '0;
            end
            foreach (status_hits[i])
                status_hits[i] = 0;
        endfunction

        // Return the slot that holds s, or -1
        function int find_held(logic [15:0] s);
            int slot;
            slot = -1;
            for (int i = HELD_DEPTH - 1; i >= 0; i--)
                if (held_valid[i] && held_seq[i] == s)
                    slot = i;
            return slot;
        endfunction

        // Predict the result of one accepted transfer and queue it
        function arrival_status_t note_arrival(logic [15:0] seq, logic [15:0] base);
            logic [15:0]     ahead;
            logic [15:0]     offset;
            arrival_status_t status;
            ack_report_t     rpt;
            int              slot;
            int unsigned     count;
            int unsigned     steps;
            bit              placed;

            // adopt the peer's base on the first transfer
            if (!started)
            begin
                next_seq = base;
                started = 1'b1;
            end

            ahead = seq - next_seq;
            if (ahead == 16'd0)
            begin
                // advance, then take every held number that is now in order
                status = ST_IN_ORDER;
                next_seq = next_seq + 16'd1;
                steps = 0;
                slot = find_held(next_seq);
                while (slot >= 0)
                begin
                    held_valid[slot] = 1'b0;
                    next_seq = next_seq + 16'd1;
                    steps++;
                    slot = find_held(next_seq);
                end
                if (steps > longest_catch_up)
                    longest_catch_up = steps;
            end
            else if (ahead < 16'h8000 && ahead < REORDER_SPAN)
            begin
                if (find_held(seq) >= 0)
                    status = ST_DUPLICATE;
                else
                begin
                    // store in the lowest free slot, or drop if none
                    status = ST_FULL;
                    placed = 1'b0;
                    for (int i = 0; i < HELD_DEPTH; i++)
                    begin
                        if (!placed && !held_valid[i])
                        begin
                            held_valid[i] = 1'b1;
                            held_seq[i] = seq;
                            status = ST_STORED;
                            placed = 1'b1;
                        end
                    end
                end
            end
            else
                status = ST_STALE;

            // build the bitmap from what is held after the update
            rpt.sack = '0;
            count = 0;
            for (int i = 0; i < HELD_DEPTH; i++)
            begin
                if (held_valid[i])
                begin
                    count++;
                    offset = held_seq[i] - next_seq - 16'd1;
                    if (offset < SACK_BITS)
                        rpt.sack[offset] = 1'b1;
                end
            end
            rpt.expected_next = next_seq;
            rpt.has_gap = (count != 0);
            rpt.held_count = count[5:0];
            rpt.status = status;
            pending_reports.push_back(rpt);

            status_hits[int'(status)]++;
            if (count > deepest_store)
                deepest_store = count;
            return status;
        endfunction

        // Compare one observed result with the oldest prediction
        function void check_report(logic [15:0] exp_next, logic [63:0] lo, logic [63:0] hi,
                                   logic gap, logic [5:0] cnt, logic [2:0] st);
            ack_report_t want;
            logic [127:0] got_sack;

            if (pending_reports.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("[sb] %0t: result with nothing pending (next %h status %0d)",
                             $realtime, exp_next, st);
                return;
            end
            want = pending_reports.pop_front();
            reports_checked++;
            got_sack = {hi, lo};
            if (want.expected_next !== exp_next || want.sack !== got_sack ||
                want.has_gap !== gap || want.held_count !== cnt || want.status !== st)
            begin
                faults++;
                if (faults <= 10)
                begin
                    $display("[sb] %0t: mismatch on report %0d", $realtime, reports_checked);
                    $display("  expected_next exp %h got %h", want.expected_next, exp_next);
                    $display("  sack          exp %h got %h", want.sack, got_sack);
                    $display("  has_gap %0d/%0b held_count %0d/%0d status %0d/%0d (exp/got)",
                             want.has_gap, gap, want.held_count, cnt, want.status, st);
                end
            end
        endfunction

    endclass

endpackage

// File: bench/tb_top.sv
// Top-level bench for the selective-ack receive tracker: clock, reset, stimulus and final check.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import sart_pkg::*;
    import sart_scoreboard_pkg::*;

    localparam int RANDOM_ITEMS = 850;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [15:0] arrived_seq = '0;
    logic [15:0] peer_window_base = '0;
    logic        busy;
    logic        done;
    logic [15:0] expected_next;
    logic [63:0] sack_low;
    logic [63:0] sack_high;
    logic        has_gap;
    logic [5:0]  held_count;
    logic [2:0]  arrival_status;

    receive_window_scoreboard board;
    int unsigned sender_idle_pct = 0;
    int unsigned counted_items = 0;
    int unsigned transfers = 0;
    int          lineup [0:255];
    int unsigned idle_pct_by_phase [4] = '{0, 59, 13, 0};

    selective_ack_receive_tracker dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .arrived_seq      (arrived_seq),
        .peer_window_base (peer_window_base),
        .done             (done),
        .expected_next    (expected_next),
        .sack_low         (sack_low),
        .sack_high        (sack_high),
        .has_gap          (has_gap),
        .held_count       (held_count),
        .arrival_status   (arrival_status)
    );

    // Generate the clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Stop a hung run
    initial
    begin
        #8ms;
        $display("tb: failure");
        $finish;
    end

    // Check each result in its strobe cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_report(expected_next, sack_low, sack_high, has_gap, held_count,
                               arrival_status);
    end

    // Offer one arrival and hold it until the tracker takes the transfer
    task automatic send_arrival(input logic [15:0] seq, input logic [15:0] base);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        arrived_seq <= seq;
        peer_window_base <= base;
        do
            @(posedge clk);
        while (busy);
        void'(board.note_arrival(seq, base));
        transfers++;
        counted_items++;
    endtask

    // Shuffle the first cnt entries of the lineup
    task automatic shuffle_lineup(input int cnt);
        int j;
        int tmp;
        for (int i = cnt - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = lineup[i];
            lineup[i] = lineup[j];
            lineup[j] = tmp;
        end
    endtask

    initial
    begin
        logic [15:0] anchor;
        int          k;
        int          n;
        int          slot;
        int          waited;

        board = new();

        // Hold reset low, then release it
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first arrival adopts the base, wrap, range edges, bitmap edges
        send_arrival(16'hffff, 16'hfffe);   // first arrival, one ahead of the adopted base
        send_arrival(16'hffff, 16'h0000);   // already held
        send_arrival(16'hfffe, 16'hffff);   // in order, catch-up wraps to zero
        send_arrival(16'h0fff, 16'h0000);   // furthest accepted, beyond the bitmap
        send_arrival(16'h1000, 16'hffff);   // just out of range
        send_arrival(16'h8000, 16'h0000);   // half the sequence space away
        send_arrival(16'h8001, 16'hffff);   // behind
        send_arrival(16'hffff, 16'h0000);   // one behind
        send_arrival(16'h0001, 16'hffff);   // bitmap bit 0
        send_arrival(16'h0040, 16'h0000);   // bitmap bit 63
        send_arrival(16'h0041, 16'hffff);   // bitmap bit 64
        send_arrival(16'h0080, 16'h0000);   // bitmap bit 127
        send_arrival(16'h0081, 16'hffff);   // held one past the bitmap
        send_arrival(16'h0000, 16'h0000);   // in order, takes bit 0 along

        // Random: mostly reordered windows around the expected number, plus noise
        counted_items = 0;
        while (counted_items < RANDOM_ITEMS)
        begin
            sender_idle_pct = idle_pct_by_phase[(counted_items * 4) / RANDOM_ITEMS];
            anchor = board.next_seq;
            case ($urandom_range(9))
                0, 1, 2, 3:
                begin
                    // reordered window with some drops and repeats
                    k = $urandom_range(1, 16);
                    for (int i = 0; i < k; i++)
                        lineup[i] = i;
                    shuffle_lineup(k);
                    for (int i = 0; i < k; i++)
                    begin
                        if ($urandom_range(7) != 0)
                            send_arrival(anchor + 16'(lineup[i]), 16'($urandom));
                        if ($urandom_range(7) == 0)
                            send_arrival(anchor + 16'(lineup[i]), 16'($urandom));
                    end
                end
                4, 5:
                begin
                    // fill ahead, maybe past a full store, then release the chain
                    k = $urandom_range(1, 34);
                    for (int i = 0; i < k; i++)
                        lineup[i] = i + 1;
                    shuffle_lineup(k);
                    for (int i = 0; i < k; i++)
                        send_arrival(anchor + 16'(lineup[i]), 16'($urandom));
                    send_arrival(anchor, 16'($urandom));
                end
                6:
                begin
                    // scatter over a wide window, then sweep it in order
                    k = $urandom_range(40, 130);
                    for (int i = 0; i < 50; i++)
                        send_arrival(anchor + 16'($urandom_range(1, k - 1)), 16'($urandom));
                    for (int i = 0; i < k; i++)
                        send_arrival(anchor + 16'(i), 16'($urandom));
                end
                7:
                begin
                    // plain in-order run
                    n = $urandom_range(1, 8);
                    for (int i = 0; i < n; i++)
                        send_arrival(board.next_seq, 16'($urandom));
                end
                default:
                begin
                    // noise: behind, too far, anything, or a held repeat
                    n = $urandom_range(1, 6);
                    for (int i = 0; i < n; i++)
                    begin
                        anchor = board.next_seq;
                        case ($urandom_range(3))
                            0: send_arrival(anchor - 16'($urandom_range(1, 32768)),
                                            16'($urandom));
                            1: send_arrival(anchor + 16'($urandom_range(4096, 32767)),
                                            16'($urandom));
                            2: send_arrival(16'($urandom), 16'($urandom));
                            default:
                            begin
                                slot = $urandom_range(HELD_DEPTH - 1);
                                if (board.held_valid[slot])
                                    send_arrival(board.held_seq[slot], 16'($urandom));
                                else
                                    send_arrival(anchor - 16'd1, 16'($urandom));
                            end
                        endcase
                    end
                end
            endcase
        end
        start <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        waited = 0;
        while (board.pending_reports.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (80) @(posedge clk);
        if (board.pending_reports.size() != 0)
        begin
            $display("[sb] %0d expected reports never arrived", board.pending_reports.size());
            board.faults++;
        end

        $write("Covered %0d transfers: %0d in order, %0d stored, ",
               transfers, board.status_hits[ST_IN_ORDER], board.status_hits[ST_STORED]);
        $display("%0d held repeats, %0d stale or far, %0d dropped on full store",
                 board.status_hits[ST_DUPLICATE], board.status_hits[ST_STALE],
                 board.status_hits[ST_FULL]);
        $display("Deepest store %0d of %0d, longest catch-up %0d, %0d reports checked, %0d faults",
                 board.deepest_store, HELD_DEPTH, board.longest_catch_up,
                 board.reports_checked, board.faults);
        if (board.faults == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
hdl/sart_pkg.sv
hdl/sart_datapath.sv
hdl/sart_ctrl.sv
hdl/selective_ack_receive_tracker.sv
bench/sart_scoreboard_pkg.sv
bench/tb_top.sv
